### sv/assert_macros.svh
// assertion macros used by the top rtl file of the window statistics block
// no dependencies; the checks drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check on every clock edge outside reset
`define SWD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define SWD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SWD_ASSERT(label, clk, rst_n, prop, msg)
`define SWD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### sv/swd_pkg.sv
// shared constants and helpers for the sliding window mean / deviation block
// no dependencies
`default_nettype none

package swd_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int STD_W      = 23;
    localparam int WINDOW_DEF = 16;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 48;

    localparam logic [STD_W-1:0] STD_MAX = 23'h7FFFFF;

    // round a width up to an even number of bits
    function automatic int even_w(input int w);
        return w + (w & 1);
    endfunction

endpackage

`default_nettype wire

### sv/swd_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module swd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/swd_div.sv
// serial unsigned divider, two quotient bits per cycle (restoring)
// depends on swd_pkg
`default_nettype none

module swd_div #(
    parameter int DVD_W = 52,
    parameter int DVS_W = 5
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  busy,
    output logic      [DVD_W-1:0] quotient
);

    import swd_pkg::*;

    localparam int DVE_W  = even_w(DVD_W);
    localparam int STEPS  = DVE_W / 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic [DVE_W-1:0]  dvd_reg;
    logic [DVE_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;

    logic [DVS_W:0]    r1;
    logic [DVS_W:0]    r2;
    logic [DVS_W-1:0]  r1_rem;
    logic [DVS_W-1:0]  rem_next;
    logic              ge1;
    logic              ge2;

    // two restoring steps per cycle on the narrow remainder
    always_comb begin
        r1       = {rem_reg, dvd_reg[DVE_W-1]};
        ge1      = (r1 >= {1'b0, dvs_reg});
        r1_rem   = ge1 ? DVS_W'(r1 - {1'b0, dvs_reg}) : r1[DVS_W-1:0];
        r2       = {r1_rem, dvd_reg[DVE_W-2]};
        ge2      = (r2 >= {1'b0, dvs_reg});
        rem_next = ge2 ? DVS_W'(r2 - {1'b0, dvs_reg}) : r2[DVS_W-1:0];
    end

    // iteration control and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            dvd_reg  <= DVE_W'(dividend);
            dvs_reg  <= divisor;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            dvd_reg  <= {dvd_reg[DVE_W-3:0], 2'b00};
            quo_reg  <= {quo_reg[DVE_W-3:0], ge1, ge2};
            rem_reg  <= rem_next;
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg[DVD_W-1:0];

endmodule

`default_nettype wire

### sv/swd_isqrt.sv
// serial floor square root, one result bit per cycle
// depends on swd_pkg
`default_nettype none

module swd_isqrt #(
    parameter int OP_W = 52,
    localparam int ROOT_W = swd_pkg::even_w(OP_W) / 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [OP_W-1:0]   operand,
    output logic                   busy,
    output logic      [ROOT_W-1:0] root
);

    import swd_pkg::*;

    localparam int OPE_W  = even_w(OP_W);
    localparam int STEPS  = OPE_W / 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic [OPE_W-1:0]  v_reg;
    logic [OPE_W-1:0]  res_reg;
    logic [OPE_W-1:0]  bit_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;

    logic [OPE_W-1:0]  trial;
    logic              ge;

    // one trial subtract per cycle
    always_comb begin
        trial = res_reg + bit_reg;
        ge    = (v_reg >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            v_reg    <= OPE_W'(operand);
            res_reg  <= '0;
            bit_reg  <= {2'b01, {(OPE_W-2){1'b0}}};
        end else if (busy_reg) begin
            if (ge) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg  <= bit_reg >> 2;
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

`default_nettype wire

### sv/sliding_window_mean_stddev_top.sv
// sliding window mean and standard deviation of Q20.4 altitude samples
// depends on swd_pkg, swd_ram, swd_div, swd_isqrt and assert_macros.svh
//
// Usage:
//   s_ channel carries one signed 24-bit sample per request in s_tdata.
//   m_ channel returns one result per sample: mean and std deviation in
//   m_tdata, the window-full flag in m_tuser.
//   The last WINDOW samples live in a ring ram; running sum and sum of
//   squares are read-modify-written per sample, then a two-bit-per-cycle
//   divider pair and a one-bit-per-cycle square root finish the statistics.
//   One sample is in flight at a time; s_tready is high only while idle.
//   A finished result sits in the output register while the next sample
//   is accepted; if m_tready stays low the block waits with the next result
//   until the register is taken.
//   Reset clears pointer, full flag and totals; the ram needs no clearing.
`default_nettype none
`include "assert_macros.svh"

module sliding_window_mean_stddev_top #(
    parameter int WINDOW = swd_pkg::WINDOW_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // sample request
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [swd_pkg::S_TDATA_W-1:0] s_tdata,  // [23:0] sample
    // result request
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [swd_pkg::M_TDATA_W-1:0] m_tdata,  // [23:0] mean, [46:24] std_dev
    output logic                               m_tuser   // [0] window_full
);

    import swd_pkg::*;

    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + PTR_W;
    localparam int SQ_W   = 2 * SAMPLE_W - 1 + PTR_W;
    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int ROOT_W = even_w(SQ_W) / 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OLD,
        S_SQ,
        S_DIV_GO,
        S_DIV,
        S_MSQ,
        S_VAR,
        S_ROOT,
        S_OUT
    } state_t;

    state_t                    state_reg;
    logic [PTR_W-1:0]          ptr_reg;
    logic                      full_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [PROD_W-1:0]         old_sq_reg;
    logic [PROD_W-1:0]         new_sq_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [SAMPLE_W-1:0] mean_reg;
    logic [PROD_W-1:0]         msq_reg;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;
    logic                      m_tuser_reg;

    logic                      accept;
    logic [SAMPLE_W-1:0]       ram_rd_data;
    logic signed [SAMPLE_W-1:0] old_sample;
    logic [PTR_W-1:0]          ptr_next;
    logic                      full_next;
    logic [CNT_W-1:0]          cnt_next;
    logic [SUM_W-1:0]          sum_mag;
    logic [SUM_W-1:0]          sum_quo;
    logic [SQ_W-1:0]           sq_quo;
    logic [SQ_W-1:0]           msq_ext;
    logic [SQ_W-1:0]           var_op;
    logic [ROOT_W-1:0]         root;
    logic [STD_W-1:0]          std_sat;
    logic [SUM_W-1:0]          mean_full;
    logic                      div_start;
    logic                      sqrt_start;
    logic                      sum_busy;
    logic                      sq_busy;
    logic                      root_busy;
    logic                      out_free;
    logic                      out_load;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == S_OUT) && out_free;

    // ring of the last WINDOW samples
    swd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (state_reg == S_OLD),
        .wr_addr (ptr_reg),
        .wr_data (sample_reg),
        .rd_en   (accept),
        .rd_addr (ptr_reg),
        .rd_data (ram_rd_data)
    );

    // pointer advance, fill state and element count
    always_comb begin
        old_sample = full_reg ? $signed(ram_rd_data) : '0;
        ptr_next   = (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
        full_next  = full_reg || (ptr_reg == PTR_W'(WINDOW - 1));
        cnt_next   = full_next ? CNT_W'(WINDOW) : CNT_W'(ptr_next);
    end

    // divider operands: sum by magnitude, sign restored afterwards
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign mean_full = sum_reg[SUM_W-1] ? SUM_W'(-sum_quo) : sum_quo;
    assign div_start = (state_reg == S_DIV_GO);

    swd_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_sum_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (cnt_reg),
        .busy     (sum_busy),
        .quotient (sum_quo)
    );

    swd_div #(
        .DVD_W (SQ_W),
        .DVS_W (CNT_W)
    ) u_sq_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sq_reg),
        .divisor  (cnt_reg),
        .busy     (sq_busy),
        .quotient (sq_quo)
    );

    // variance, clamped at zero when the mean square exceeds it
    assign msq_ext    = SQ_W'(msq_reg);
    assign var_op     = (sq_quo > msq_ext) ? sq_quo - msq_ext : '0;
    assign sqrt_start = (state_reg == S_VAR);

    swd_isqrt #(
        .OP_W (SQ_W)
    ) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .operand (var_op),
        .busy    (root_busy),
        .root    (root)
    );

    assign std_sat = (root > ROOT_W'(STD_MAX)) ? STD_MAX : root[STD_W-1:0];

    // sequencer, running totals and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ptr_reg      <= '0;
            full_reg     <= 1'b0;
            sum_reg      <= '0;
            sq_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        sample_reg <= $signed(s_tdata[SAMPLE_W-1:0]);
                        state_reg  <= S_OLD;
                    end
                end
                S_OLD: begin
                    old_sq_reg <= PROD_W'(old_sample * old_sample);
                    new_sq_reg <= PROD_W'(sample_reg * sample_reg);
                    sum_reg    <= sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
                    ptr_reg    <= ptr_next;
                    full_reg   <= full_next;
                    cnt_reg    <= cnt_next;
                    state_reg  <= S_SQ;
                end
                S_SQ: begin
                    sq_reg    <= sq_reg - SQ_W'(old_sq_reg) + SQ_W'(new_sq_reg);
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (!sum_busy && !sq_busy) begin
                        mean_reg  <= $signed(mean_full[SAMPLE_W-1:0]);
                        state_reg <= S_MSQ;
                    end
                end
                S_MSQ: begin
                    msq_reg   <= PROD_W'(mean_reg * mean_reg);
                    state_reg <= S_VAR;
                end
                S_VAR: begin
                    state_reg <= S_ROOT;
                end
                S_ROOT: begin
                    if (!root_busy) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, std_sat, mean_reg};
                        m_tuser_reg  <= full_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `SWD_ASSERT(a_idle_units, aclk, aresetn, s_tready |-> (!sum_busy && !sq_busy && !root_busy), "serial unit busy while idle")
    `SWD_ASSERT(a_full_sticky, aclk, aresetn, full_reg |=> full_reg, "window full flag dropped")
    `SWD_ASSERT(a_ptr_range, aclk, aresetn, ptr_reg <= PTR_W'(WINDOW - 1), "write pointer out of range")
    `SWD_ASSERT(a_cnt_nonzero, aclk, aresetn, div_start |-> (cnt_reg != '0), "divide by zero count")
    `SWD_ASSERT(a_out_source, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT), "result raised outside output state")

endmodule

`default_nettype wire
